/* sv/indexed_min_heap_with_handles_defines.svh */
// Assertion macros used by the checker file.
`ifndef INDEXED_MIN_HEAP_WITH_HANDLES_DEFINES_SVH
`define INDEXED_MIN_HEAP_WITH_HANDLES_DEFINES_SVH

// Clocked implication, disabled in reset.
`define IMHH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset.
`define IMHH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/imhh_pkg.sv */
package imhh_pkg;

	localparam int CAPACITY = 64;
	localparam int ID_W     = 7;
	localparam int SCORE_W  = 32;
	localparam int MODE_W   = 3;
	localparam int STATUS_W = 3;

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT = 3'd0,
		MODE_FIND   = 3'd1,
		MODE_RAISE  = 3'd2,
		MODE_LOWER  = 3'd3,
		MODE_REMOVE = 3'd4
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 3'd0,
		ST_ABSENT  = 3'd1,
		ST_PRESENT = 3'd2,
		ST_FULL    = 3'd3,
		ST_EMPTY   = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_RDS,
		S_UP,
		S_UPC,
		S_DN,
		S_DNL,
		S_DNR,
		S_DNM,
		S_FIN,
		S_RM1,
		S_RM2,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]           id;
		logic signed [SCORE_W-1:0] score;
	} slot_t;

endpackage

/* sv/indexed_min_heap_with_handles.sv */
// Indexed min priority queue: a binary min-heap of (id, score) entries kept in
// one slot memory, plus a handle memory giving each id its heap slot. Each
// request (insert, find, raise, lower, remove minimum) gives exactly one
// result with status, id and score. One slot-memory read port and one write
// port; the entry being placed is held in registers and the hole walks up or
// down, so every level costs one or two reads and at most one move. A rejected
// request walks no level, find reads one slot, insert climbs, remove descends,
// and raise or lower climbs or else descends. in_ready is high only in idle; a
// finished result sits in an output register until taken, and the next request
// is accepted meanwhile. The handle memory has per-id valid bits cleared by
// reset, so no clearing pass is needed.
module indexed_min_heap_with_handles (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [imhh_pkg::MODE_W-1:0]           mode,
	input  logic [imhh_pkg::ID_W-1:0]             key_id,
	input  logic signed [imhh_pkg::SCORE_W-1:0]   amount,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [imhh_pkg::STATUS_W-1:0]         status,
	output logic [imhh_pkg::ID_W-1:0]             result_id,
	output logic signed [imhh_pkg::SCORE_W-1:0]   result_score
);

	// Address width covers slots 1..CAPACITY and ids 0..CAPACITY.
	localparam int AW = $clog2(imhh_pkg::CAPACITY + 1);

	imhh_pkg::state_t state_q, state_d;

	// request
	logic [imhh_pkg::MODE_W-1:0]         mode_q;
	logic [imhh_pkg::ID_W-1:0]           id_q;
	logic signed [imhh_pkg::SCORE_W-1:0] amt_q;

	// heap bookkeeping
	logic [AW-1:0]   cnt_q;
	logic [AW-1:0]   pos_q;       // current hole
	imhh_pkg::slot_t cur_q;       // entry being placed
	imhh_pkg::slot_t best_q;      // smallest of hole and children
	logic [AW-1:0]   bpos_q;
	logic            moved_q;

	// result
	logic [imhh_pkg::STATUS_W-1:0]       res_st_q;
	logic [imhh_pkg::ID_W-1:0]           res_id_q;
	logic signed [imhh_pkg::SCORE_W-1:0] res_sc_q;
	logic                                out_valid_q;
	logic [imhh_pkg::STATUS_W-1:0]       out_st_q;
	logic [imhh_pkg::ID_W-1:0]           out_id_q;
	logic signed [imhh_pkg::SCORE_W-1:0] out_sc_q;

	// slot memory
	imhh_pkg::slot_t hp_mem [imhh_pkg::CAPACITY+1];
	imhh_pkg::slot_t hp_rd_q;
	logic [AW-1:0]   hp_ra;
	logic            hp_we;
	logic [AW-1:0]   hp_wa;
	imhh_pkg::slot_t hp_wd;

	// handle memory with valid bits
	logic [AW-1:0]   hd_mem [imhh_pkg::CAPACITY+1];
	logic [imhh_pkg::CAPACITY:0] hv_q;
	logic [AW-1:0]   hd_rd_q;
	logic            hv_rd_q;
	logic [AW-1:0]   hd_ra;
	logic            hd_we;
	logic [AW-1:0]   hd_wa;
	logic [AW-1:0]   hd_wd;

	logic [AW-1:0]   h_cur;
	logic            id_ok;
	logic            is_ins, is_find, is_adj, is_rm;
	logic            full, absent;
	logic [AW:0]     lch, rch;
	logic            do_load;
	logic signed [imhh_pkg::SCORE_W:0] sum;
	logic signed [imhh_pkg::SCORE_W-1:0] new_sc;
	logic            up_move, dn_move;

	assign h_cur   = hv_rd_q ? hd_rd_q : '0;
	assign id_ok   = (id_q != '0) && ({25'd0, id_q} <= 32'(imhh_pkg::CAPACITY));
	assign is_ins  = (mode_q == imhh_pkg::MODE_INSERT);
	assign is_find = (mode_q == imhh_pkg::MODE_FIND);
	assign is_adj  = (mode_q == imhh_pkg::MODE_RAISE) || (mode_q == imhh_pkg::MODE_LOWER);
	assign is_rm   = (mode_q == imhh_pkg::MODE_REMOVE);
	assign full    = ({{(32-AW){1'b0}}, cnt_q} >= 32'(imhh_pkg::CAPACITY));
	assign absent  = (h_cur == '0) || (h_cur > cnt_q);
	assign lch     = {pos_q, 1'b0};
	assign rch     = lch + (AW+1)'(1);
	assign up_move = (hp_rd_q.score > cur_q.score);
	assign dn_move = (bpos_q != pos_q);
	assign do_load = (state_q == imhh_pkg::S_DONE) && (!out_valid_q || out_ready);

	// saturating raise / lower
	always_comb begin
		if (mode_q == imhh_pkg::MODE_RAISE)
			sum = {hp_rd_q.score[31], hp_rd_q.score} + {amt_q[31], amt_q};
		else
			sum = {hp_rd_q.score[31], hp_rd_q.score} - {amt_q[31], amt_q};
		if (sum[32] != sum[31])
			new_sc = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		else
			new_sc = sum[31:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			imhh_pkg::S_IDLE:  if (in_valid) state_d = imhh_pkg::S_CHECK;
			imhh_pkg::S_CHECK: begin
				if (is_rm)
					state_d = (cnt_q == '0) ? imhh_pkg::S_DONE : imhh_pkg::S_RM1;
				else if (!(is_ins || is_find || is_adj) || !id_ok)
					state_d = imhh_pkg::S_DONE;
				else if (is_ins)
					state_d = (full || !absent) ? imhh_pkg::S_DONE : imhh_pkg::S_UP;
				else
					state_d = absent ? imhh_pkg::S_DONE : imhh_pkg::S_RDS;
			end
			imhh_pkg::S_RDS:   state_d = is_find ? imhh_pkg::S_DONE : imhh_pkg::S_UP;
			imhh_pkg::S_UP:
				state_d = (pos_q == AW'(1)) ?
					(is_ins ? imhh_pkg::S_FIN : (moved_q ? imhh_pkg::S_FIN : imhh_pkg::S_DN))
					: imhh_pkg::S_UPC;
			imhh_pkg::S_UPC: begin
				if (up_move)         state_d = imhh_pkg::S_UP;
				else if (moved_q || is_ins) state_d = imhh_pkg::S_FIN;
				else                 state_d = imhh_pkg::S_DN;
			end
			imhh_pkg::S_DN:
				state_d = (lch > {1'b0, cnt_q}) ? imhh_pkg::S_FIN : imhh_pkg::S_DNL;
			imhh_pkg::S_DNL:
				state_d = (rch > {1'b0, cnt_q}) ? imhh_pkg::S_DNM : imhh_pkg::S_DNR;
			imhh_pkg::S_DNR:   state_d = imhh_pkg::S_DNM;
			imhh_pkg::S_DNM:   state_d = dn_move ? imhh_pkg::S_DN : imhh_pkg::S_FIN;
			imhh_pkg::S_FIN:   state_d = imhh_pkg::S_DONE;
			imhh_pkg::S_RM1:
				state_d = (cnt_q > AW'(1)) ? imhh_pkg::S_RM2 : imhh_pkg::S_DONE;
			imhh_pkg::S_RM2:   state_d = imhh_pkg::S_DN;
			imhh_pkg::S_DONE:  if (do_load) state_d = imhh_pkg::S_IDLE;
			default:           state_d = imhh_pkg::S_IDLE;
		endcase
	end

	// memory ports and handshake
	always_comb begin
		in_ready = 1'b0;
		hp_ra    = pos_q;
		hp_we    = 1'b0;
		hp_wa    = pos_q;
		hp_wd    = cur_q;
		hd_ra    = AW'(key_id);
		hd_we    = 1'b0;
		hd_wa    = AW'(cur_q.id);
		hd_wd    = pos_q;
		unique case (state_q)
			imhh_pkg::S_IDLE:  in_ready = 1'b1;
			imhh_pkg::S_CHECK: hp_ra = is_rm ? AW'(1) : h_cur;
			imhh_pkg::S_UP:    hp_ra = pos_q >> 1;
			imhh_pkg::S_UPC: begin
				hp_we = up_move;
				hp_wd = hp_rd_q;
				hd_we = up_move;
				hd_wa = AW'(hp_rd_q.id);
			end
			imhh_pkg::S_DN:    hp_ra = lch[AW-1:0];
			imhh_pkg::S_DNL:   hp_ra = rch[AW-1:0];
			imhh_pkg::S_DNM: begin
				hp_we = dn_move;
				hp_wd = best_q;
				hd_we = dn_move;
				hd_wa = AW'(best_q.id);
			end
			imhh_pkg::S_FIN: begin
				hp_we = 1'b1;
				hd_we = 1'b1;
			end
			imhh_pkg::S_RM1: begin
				hp_ra = cnt_q;
				hd_we = 1'b1;
				hd_wa = AW'(hp_rd_q.id);
				hd_wd = '0;            // removed id becomes absent
			end
			default: ;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		hp_rd_q <= hp_mem[hp_ra];
		if (hp_we) hp_mem[hp_wa] <= hp_wd;
		hd_rd_q <= hd_mem[hd_ra];
		hv_rd_q <= hv_q[hd_ra];
		if (hd_we) hd_mem[hd_wa] <= hd_wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q <= '0;
		end else if (hd_we) begin
			hv_q[hd_wa] <= 1'b1;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= imhh_pkg::S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == imhh_pkg::S_CHECK && is_ins && id_ok && !full && absent)
				cnt_q <= cnt_q + AW'(1);
			if (state_q == imhh_pkg::S_RM1)
				cnt_q <= cnt_q - AW'(1);
			if (do_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_q <= mode;
			id_q   <= key_id;
			amt_q  <= amount;
		end
		if (do_load) begin
			out_st_q <= res_st_q;
			out_id_q <= res_id_q;
			out_sc_q <= res_sc_q;
		end
		case (state_q)
			imhh_pkg::S_CHECK: begin
				res_st_q <= imhh_pkg::ST_ABSENT;
				res_id_q <= id_q;
				res_sc_q <= '0;
				moved_q  <= 1'b0;
				pos_q    <= h_cur;
				cur_q    <= '{id: id_q, score: amt_q};
				if (is_rm) begin
					res_id_q <= '0;
					if (cnt_q == '0) res_st_q <= imhh_pkg::ST_EMPTY;
				end else if (!(is_ins || is_find || is_adj)) begin
					res_id_q <= '0;
				end else if (is_ins && id_ok) begin
					if (full) begin
						res_st_q <= imhh_pkg::ST_FULL;
					end else if (!absent) begin
						res_st_q <= imhh_pkg::ST_PRESENT;
					end else begin
						res_st_q <= imhh_pkg::ST_OK;
						res_sc_q <= amt_q;
						pos_q    <= cnt_q + AW'(1);
					end
				end
			end
			imhh_pkg::S_RDS: begin
				res_st_q <= imhh_pkg::ST_OK;
				if (is_find) begin
					res_sc_q <= hp_rd_q.score;
				end else begin
					res_sc_q    <= new_sc;
					cur_q.score <= new_sc;
				end
			end
			imhh_pkg::S_UPC: begin
				if (up_move) begin
					pos_q   <= pos_q >> 1;
					moved_q <= 1'b1;
				end
			end
			imhh_pkg::S_DNL: begin
				if (hp_rd_q.score < cur_q.score) begin
					best_q <= hp_rd_q;
					bpos_q <= lch[AW-1:0];
				end else begin
					best_q <= cur_q;
					bpos_q <= pos_q;
				end
			end
			imhh_pkg::S_DNR: begin
				if (hp_rd_q.score < best_q.score) begin
					best_q <= hp_rd_q;
					bpos_q <= rch[AW-1:0];
				end
			end
			imhh_pkg::S_DNM: if (dn_move) pos_q <= bpos_q;
			imhh_pkg::S_RM1: begin
				res_st_q <= imhh_pkg::ST_OK;
				res_id_q <= hp_rd_q.id;
				res_sc_q <= hp_rd_q.score;
			end
			imhh_pkg::S_RM2: begin
				cur_q <= hp_rd_q;       // last entry refills the root
				pos_q <= AW'(1);
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign status       = out_st_q;
	assign result_id    = out_id_q;
	assign result_score = out_sc_q;

endmodule

/* sv/imhh_checker.sv */
`include "indexed_min_heap_with_handles_defines.svh"

module imhh_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [imhh_pkg::STATUS_W-1:0]       status,
	input logic [imhh_pkg::ID_W-1:0]           result_id,
	input logic signed [imhh_pkg::SCORE_W-1:0] result_score
);

	// one request at a time
	`IMHH_ASSERT_NXT(a_busy_after_req, clk, arst_n, in_valid && in_ready, !in_ready, "ready after request")

	// failed requests report a zero score
	`IMHH_ASSERT_IMP(a_fail_zero, clk, arst_n, out_valid && (status != imhh_pkg::ST_OK), result_score == '0, "nonzero score on failure")

	// empty heap reports no id
	`IMHH_ASSERT_IMP(a_empty_id, clk, arst_n, out_valid && (status == imhh_pkg::ST_EMPTY), result_id == '0, "id on empty")

	// held result stays put
	`IMHH_ASSERT_NXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(result_id) && $stable(result_score), "result changed while stalled")

endmodule

bind indexed_min_heap_with_handles imhh_checker u_imhh_checker (.*);

/* dv/indexed_min_heap_with_handles_test.sv */
`timescale 1ns / 100ps

module indexed_min_heap_with_handles_test;

	localparam int CAP = imhh_pkg::CAPACITY;
	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [imhh_pkg::MODE_W-1:0] mode = '0;
	logic [imhh_pkg::ID_W-1:0] key_id = '0;
	logic signed [imhh_pkg::SCORE_W-1:0] amount = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [imhh_pkg::STATUS_W-1:0] status;
	logic [imhh_pkg::ID_W-1:0] result_id;
	logic signed [imhh_pkg::SCORE_W-1:0] result_score;

	indexed_min_heap_with_handles i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .key_id(key_id), .amount(amount),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .result_id(result_id), .result_score(result_score)
	);

	always #4 clk = ~clk;

	typedef struct {
		logic [imhh_pkg::STATUS_W-1:0] st;
		logic [imhh_pkg::ID_W-1:0] id;
		logic signed [imhh_pkg::SCORE_W-1:0] score;
	} heap_result_t;

	// predictor copy of the heap
	logic [imhh_pkg::ID_W-1:0] ph_id [1:CAP];
	logic signed [imhh_pkg::SCORE_W-1:0] ph_score [1:CAP];
	int ph_handle [0:CAP];
	int ph_count;

	heap_result_t pending_results[$];
	int errors;
	int idle_cycles;
	bit bursty;      // random idling on both sides
	bit hold_sink;   // long receiver hold-off

	function automatic logic signed [imhh_pkg::SCORE_W-1:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic void slot_swap(int a, int b);
		logic [imhh_pkg::ID_W-1:0] ti;
		logic signed [imhh_pkg::SCORE_W-1:0] ts;
		ti = ph_id[a]; ts = ph_score[a];
		ph_id[a] = ph_id[b]; ph_score[a] = ph_score[b];
		ph_id[b] = ti; ph_score[b] = ts;
		ph_handle[ph_id[a]] = a;
		ph_handle[ph_id[b]] = b;
	endfunction

	function automatic void climb(int i);
		while (i > 1 && ph_score[i/2] > ph_score[i]) begin
			slot_swap(i, i/2);
			i = i/2;
		end
	endfunction

	function automatic void descend(int i);
		int l, r, m;
		forever begin
			l = 2*i; r = l+1; m = i;
			if (l <= ph_count && ph_score[l] < ph_score[m]) m = l;
			if (r <= ph_count && ph_score[r] < ph_score[m]) m = r;
			if (m == i) return;
			slot_swap(i, m);
			i = m;
		end
	endfunction

	function automatic heap_result_t heap_predict(logic [imhh_pkg::MODE_W-1:0] md,
			logic [imhh_pkg::ID_W-1:0] id, logic signed [imhh_pkg::SCORE_W-1:0] amt);
		heap_result_t r;
		int s;
		bit ok_id;
		logic signed [imhh_pkg::SCORE_W-1:0] nv;
		r.st = imhh_pkg::ST_ABSENT; r.id = '0; r.score = '0;
		ok_id = id >= 1 && id <= CAP;
		if (md <= imhh_pkg::MODE_LOWER) begin
			r.id = id;
			if (!ok_id) begin
				r.st = imhh_pkg::ST_ABSENT;
			end else if (md == imhh_pkg::MODE_INSERT) begin
				if (ph_count >= CAP) r.st = imhh_pkg::ST_FULL;
				else if (ph_handle[id] != 0) r.st = imhh_pkg::ST_PRESENT;
				else begin
					ph_count++;
					ph_id[ph_count] = id;
					ph_score[ph_count] = amt;
					ph_handle[id] = ph_count;
					climb(ph_count);
					r.st = imhh_pkg::ST_OK;
					r.score = amt;
				end
			end else begin
				s = ph_handle[id];
				if (s == 0 || s > ph_count) begin
					r.st = imhh_pkg::ST_ABSENT;
				end else if (md == imhh_pkg::MODE_FIND) begin
					r.st = imhh_pkg::ST_OK;
					r.score = ph_score[s];
				end else begin
					nv = (md == imhh_pkg::MODE_RAISE)
						? clamp32(longint'(ph_score[s]) + longint'(amt))
						: clamp32(longint'(ph_score[s]) - longint'(amt));
					ph_score[s] = nv;
					climb(s);
					descend(ph_handle[id]);
					r.st = imhh_pkg::ST_OK;
					r.score = nv;
				end
			end
		end else if (md == imhh_pkg::MODE_REMOVE) begin
			if (ph_count == 0) begin
				r.st = imhh_pkg::ST_EMPTY;
			end else begin
				r.id = ph_id[1];
				r.score = ph_score[1];
				ph_handle[r.id] = 0;
				if (ph_count > 1) begin
					ph_id[1] = ph_id[ph_count];
					ph_score[1] = ph_score[ph_count];
					ph_handle[ph_id[1]] = 1;
				end
				ph_count--;
				descend(1);
				r.st = imhh_pkg::ST_OK;
			end
		end
		return r;
	endfunction

	// one request; valid stays high until taken, prediction at acceptance
	task automatic send_request(logic [imhh_pkg::MODE_W-1:0] md,
			logic [imhh_pkg::ID_W-1:0] id, logic signed [imhh_pkg::SCORE_W-1:0] amt);
		int gap;
		if (bursty && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		mode <= md; key_id <= id; amount <= amt; in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		pending_results.insert(pending_results.size(), heap_predict(md, id, amt));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic signed [imhh_pkg::SCORE_W-1:0] rand_score();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $urandom();
			default: return $signed($urandom_range(0, 200)) - 100;
		endcase
	endfunction

	// receiver: random bursts of stall, or a long hold-off when asked
	always @(posedge clk) begin
		if (hold_sink) out_ready <= 1'b0;
		else if (bursty && $urandom_range(0, 4) == 0) out_ready <= 1'b0;
		else out_ready <= 1'b1;
	end

	// result checker
	always @(posedge clk) begin
		heap_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (status !== e.st) begin
					$error("status exp %0d got %0d", e.st, status); errors++;
				end
				if (result_id !== e.id) begin
					$error("result_id exp %0d got %0d", e.id, result_id); errors++;
				end
				if (result_score !== e.score) begin
					$error("result_score exp %0d got %0d", e.score, result_score);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no request or result moving
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// field extremes, every mode, every error status but full
	task automatic test_directed();
		send_request(imhh_pkg::MODE_REMOVE, 7'd0, 0);           // empty heap
		send_request(imhh_pkg::MODE_FIND, 7'd5, 0);             // absent
		send_request(imhh_pkg::MODE_INSERT, 7'd0, 5);           // id zero
		send_request(imhh_pkg::MODE_INSERT, 7'd65, 5);          // id above capacity
		send_request(imhh_pkg::MODE_INSERT, 7'd127, -1);
		send_request(imhh_pkg::MODE_INSERT, 7'd1, 32'sh7fffffff);
		send_request(imhh_pkg::MODE_INSERT, 7'd64, 32'sh80000000);
		send_request(imhh_pkg::MODE_INSERT, 7'd1, 3);           // already present
		send_request(imhh_pkg::MODE_INSERT, 7'd2, 0);
		send_request(imhh_pkg::MODE_INSERT, 7'd3, 0);           // tie
		send_request(imhh_pkg::MODE_RAISE, 7'd1, 10);           // saturate high
		send_request(imhh_pkg::MODE_LOWER, 7'd64, 10);          // saturate low
		send_request(imhh_pkg::MODE_RAISE, 7'd2, -50);          // negative change sifts up
		send_request(imhh_pkg::MODE_LOWER, 7'd3, -70);          // negative change sifts down
		send_request(imhh_pkg::MODE_FIND, 7'd3, 0);
		send_request(3'd5, 7'd3, 0);                            // unused modes
		send_request(3'd7, 7'd127, 32'shffffffff);
		send_request(imhh_pkg::MODE_RAISE, 7'd9, 1);
		send_request(imhh_pkg::MODE_REMOVE, 7'd1, 0);
		send_request(imhh_pkg::MODE_REMOVE, 7'd0, 0);
		send_request(imhh_pkg::MODE_REMOVE, 7'd0, 0);
		send_request(imhh_pkg::MODE_REMOVE, 7'd0, 0);
		send_request(imhh_pkg::MODE_REMOVE, 7'd0, 0);
		send_request(imhh_pkg::MODE_REMOVE, 7'd0, 0);           // empty again
		drain_results();
	endtask

	// fill to capacity and overflow, with the receiver held off long enough
	// for the block to stall its input
	task automatic test_full_heap();
		int k;
		hold_sink = 1'b1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_sink = 1'b0;
			end
		join_none
		for (k = 1; k <= CAP; k++)
			send_request(imhh_pkg::MODE_INSERT, k[imhh_pkg::ID_W-1:0], rand_score());
		send_request(imhh_pkg::MODE_INSERT, 7'd5, 1);            // full
		send_request(imhh_pkg::MODE_INSERT, 7'd0, 1);
		drain_results();
		for (k = 0; k < CAP; k++) send_request(imhh_pkg::MODE_REMOVE, 7'd0, 0);
		drain_results();
	endtask

	// random traffic, mostly valid ids, mixed sizes of heap
	task automatic test_random(int n);
		int k;
		logic [imhh_pkg::MODE_W-1:0] md;
		logic [imhh_pkg::ID_W-1:0] id;
		for (k = 0; k < n; k++) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5: md = imhh_pkg::MODE_INSERT;
				6, 7: md = imhh_pkg::MODE_FIND;
				8, 9, 10: md = imhh_pkg::MODE_RAISE;
				11, 12, 13: md = imhh_pkg::MODE_LOWER;
				14, 15, 16, 17: md = imhh_pkg::MODE_REMOVE;
				default: md = 3'($urandom_range(0, 7));
			endcase
			id = ($urandom_range(0, 15) == 0) ? 7'($urandom_range(0, 127))
				: 7'($urandom_range(1, CAP));
			send_request(md, id, rand_score());
			if (k == n / 2) drain_results();          // sender waits for all results
		end
		drain_results();
	endtask

	initial begin
		int k;
		errors = 0;
		idle_cycles = 0;
		bursty = 1'b0;
		hold_sink = 1'b0;
		ph_count = 0;
		for (k = 0; k <= CAP; k++) ph_handle[k] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		bursty = 1'b1;
		test_directed();
		test_full_heap();
		test_random(600);
		bursty = 1'b0;
		test_random(100);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
